// ===== rtl/core/fbde_pkg.sv =====
`default_nettype none
package fbde_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_PIXEL  = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_REGION = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

endpackage
`default_nettype wire

// ===== rtl/core/fbde_ram.sv =====
`default_nettype none
module fbde_ram #(
  parameter int unsigned DEPTH = 8000,
  parameter int unsigned AW    = 13
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire  [AW-1:0]       waddr_i,
  input  fbde_pkg::word_t     wdata_i,
  input  wire                 re_i,
  input  wire  [AW-1:0]       raddr_i,
  output fbde_pkg::word_t     rdata_o
);
  import fbde_pkg::*;

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/mono_framebuffer_draw_engine_top.sv =====
`default_nettype none
// Channel   | Direction | Signals                                   | Handshake
// ----------+-----------+-------------------------------------------+-----------------------
// request   | in        | mode_i, start_row_i .. read_address_i     | start_i && !busy_o
// result    | out       | read_data_o                               | valid_o, one cycle
//
// Every on-screen line point or clear region word is a read-modify-write through
// the one read port and one write port of the store; off-screen points are skipped.
// Reset: the store is swept to zero, one word a cycle, all SCREEN_ROWS *
// ceil(SCREEN_COLUMNS/32) words (8000 at default size); busy_o is high meanwhile.
// Stalls: the receiver cannot stall; a result is shown for one cycle only.
module mono_framebuffer_draw_engine_top #(
  parameter int unsigned SCREEN_COLUMNS = 640,
  parameter int unsigned SCREEN_ROWS    = 400
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  output logic         busy_o,
  input  wire  [1:0]   mode_i,
  input  wire  [9:0]   start_row_i,
  input  wire  [9:0]   start_col_i,
  input  wire  [9:0]   end_row_i,
  input  wire  [9:0]   end_col_i,
  input  wire  [9:0]   region_height_i,
  input  wire  [9:0]   region_width_i,
  input  wire  [12:0]  read_address_i,
  output logic         valid_o,
  output logic [31:0]  read_data_o
);
  import fbde_pkg::*;

  localparam int unsigned WPR   = (SCREEN_COLUMNS + 31) / 32;
  localparam int unsigned DEPTH = SCREEN_ROWS * WPR;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int          EW    = 14;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LPLOT, ST_LWRITE, ST_RRD, ST_RWR, ST_RESP
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]        cnt_q, cnt_d;
  logic [9:0]           r_q, r_d, c_q, c_d, er_q, er_d, ec_q, ec_d;
  logic signed [EW-1:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic                 sx_q, sx_d, sy_q, sy_d;
  logic [10:0]          rowend_q, rowend_d;
  logic [4:0]           w_q, w_d, wlo_q, wlo_d, whi_q, whi_d, clo_q, clo_d, chi_q, chi_d;
  logic [AW-1:0]        base_q, base_d;
  logic                 rd_ok_q, rd_ok_d;

  // store port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  word_t         wdata, rdata;

  fbde_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // current line point
  logic          on_screen, at_end;
  logic [AW-1:0] pix_addr, reg_addr;
  word_t         pix_bit, clr_mask;
  logic signed [EW-1:0] e2;

  assign on_screen = (32'(r_q) < SCREEN_ROWS) && (32'(c_q) < SCREEN_COLUMNS);
  assign at_end    = (r_q == er_q) && (c_q == ec_q);
  assign pix_addr  = AW'(32'(r_q) * WPR + 32'(c_q[9:5]));
  assign pix_bit   = 32'h8000_0000 >> c_q[4:0];
  assign e2        = err_q <<< 1;
  assign reg_addr  = base_q + AW'(w_q);

  // columns covered in the current word of a clear row
  always_comb begin
    word_t lo_m, hi_m;
    lo_m = (w_q == wlo_q) ? (32'hFFFF_FFFF >> clo_q) : 32'hFFFF_FFFF;
    hi_m = (w_q == whi_q) ? ~(32'hFFFF_FFFF >> ({1'b0, chi_q} + 6'd1)) : 32'hFFFF_FFFF;
    clr_mask = lo_m & hi_m;
  end

  // request decode
  logic [9:0]  dcol, drow;
  logic [10:0] cend, chi_full, rend;
  logic        reg_empty;

  always_comb begin
    dcol      = (end_col_i > start_col_i) ? end_col_i - start_col_i : start_col_i - end_col_i;
    drow      = (end_row_i > start_row_i) ? end_row_i - start_row_i : start_row_i - end_row_i;
    cend      = {1'b0, start_col_i} + {1'b0, region_width_i};
    chi_full  = (32'(cend) < SCREEN_COLUMNS) ? cend : 11'(SCREEN_COLUMNS);
    rend      = ({1'b0, start_row_i} + {1'b0, region_height_i});
    rend      = (32'(rend) < SCREEN_ROWS) ? rend : 11'(SCREEN_ROWS);
    reg_empty = (region_width_i == '0) || (region_height_i == '0)
             || (32'(start_col_i) >= SCREEN_COLUMNS) || (32'(start_row_i) >= SCREEN_ROWS);
  end

  always_comb begin
    logic [10:0] chi_m1;
    state_d  = state_q;
    cnt_d    = cnt_q;
    r_d      = r_q;
    c_d      = c_q;
    er_d     = er_q;
    ec_d     = ec_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    err_d    = err_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    rowend_d = rowend_q;
    w_d      = w_q;
    wlo_d    = wlo_q;
    whi_d    = whi_q;
    clo_d    = clo_q;
    chi_d    = chi_q;
    base_d   = base_q;
    rd_ok_d  = rd_ok_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = pix_addr;
    raddr    = pix_addr;
    wdata    = rdata | pix_bit;
    chi_m1   = chi_full - 11'd1;

    case (state_q)
      ST_CLEAR: begin
        // sweep the store to zero after reset
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + AW'(1);
        if (32'(cnt_q) == DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          r_d   = start_row_i;
          c_d   = start_col_i;
          case (mode_i)
            MODE_PIXEL, MODE_LINE: begin
              // a pixel is a line whose end is its start
              if (mode_i == MODE_PIXEL) begin
                er_d  = start_row_i;
                ec_d  = start_col_i;
                dx_d  = '0;
                dy_d  = '0;
                err_d = '0;
              end else begin
                er_d  = end_row_i;
                ec_d  = end_col_i;
                dx_d  = EW'(dcol);
                dy_d  = EW'(drow);
                err_d = EW'(dcol) - EW'(drow);
              end
              sx_d    = end_col_i > start_col_i;
              sy_d    = end_row_i > start_row_i;
              state_d = ST_LPLOT;
            end
            MODE_REGION: begin
              rowend_d = rend;
              clo_d    = start_col_i[4:0];
              wlo_d    = start_col_i[9:5];
              w_d      = start_col_i[9:5];
              chi_d    = chi_m1[4:0];
              whi_d    = chi_m1[9:5];
              base_d   = AW'(32'(start_row_i) * WPR);
              state_d  = reg_empty ? ST_IDLE : ST_RRD;
            end
            default: begin
              rd_ok_d = 32'(read_address_i) < DEPTH;
              re      = 1'b1;
              raddr   = AW'(read_address_i);
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_LPLOT, ST_LWRITE: begin
        if (state_q == ST_LPLOT && on_screen) begin
          re      = 1'b1;
          state_d = ST_LWRITE;
        end else begin
          we = (state_q == ST_LWRITE);
          if (at_end) begin
            state_d = ST_IDLE;
          end else begin
            // advance one Bresenham step
            err_d = err_q;
            if (e2 > -dy_q) begin
              err_d = err_d - dy_q;
              c_d   = sx_q ? c_q + 10'd1 : c_q - 10'd1;
            end
            if (e2 < dx_q) begin
              err_d = err_d + dx_q;
              r_d   = sy_q ? r_q + 10'd1 : r_q - 10'd1;
            end
            state_d = ST_LPLOT;
          end
        end
      end
      ST_RRD: begin
        re      = 1'b1;
        raddr   = reg_addr;
        state_d = ST_RWR;
      end
      ST_RWR: begin
        we      = 1'b1;
        waddr   = reg_addr;
        wdata   = rdata & ~clr_mask;
        state_d = ST_RRD;
        if (w_q == whi_q) begin
          w_d    = wlo_q;
          r_d    = r_q + 10'd1;
          base_d = base_q + AW'(WPR);
          if ({1'b0, r_q} + 11'd1 == rowend_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          w_d = w_q + 5'd1;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    c_q      <= c_d;
    er_q     <= er_d;
    ec_q     <= ec_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    err_q    <= err_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    rowend_q <= rowend_d;
    w_q      <= w_d;
    wlo_q    <= wlo_d;
    whi_q    <= whi_d;
    clo_q    <= clo_d;
    chi_q    <= chi_d;
    base_q   <= base_d;
    rd_ok_q  <= rd_ok_d;
  end

  // hold busy high for every state but idle; drop beyond-store reads to zero
  assign busy_o      = (state_q != ST_IDLE);
  assign valid_o     = (state_q == ST_RESP);
  assign read_data_o = rd_ok_q ? rdata : '0;

endmodule
`default_nettype wire
